### src/q2r_pkg.sv
// Shared widths and types for the quaternion to rotation matrix pipeline.
// No dependencies.
package q2r_pkg;

    localparam int FRAC = 14;              // fractional bits of each matrix entry
    localparam int QW   = FRAC + 1;        // quotient bits, value at most 2^FRAC
    localparam int NW   = 34;              // signed numerator width
    localparam int SW   = 33;              // norm width, n <= 2^32
    localparam int DW   = SW + 1;          // divisor 2n
    localparam int RW   = SW + QW + 2;     // partial remainder width
    localparam int LAT  = QW + 5;          // register stages, input to output register

    localparam logic signed [15:0] ONE16 = 16'(1 << FRAC);

    typedef logic signed [NW-1:0] num_t;
    typedef logic [SW-1:0]        norm_t;

endpackage

### src/q2r_front.sv
// Front end: component products, then norm and the nine numerators.
// Depends on q2r_pkg.
module q2r_front import q2r_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic               cmd,
    input  logic signed [15:0] qx,
    input  logic signed [15:0] qy,
    input  logic signed [15:0] qz,
    input  logic signed [15:0] qw,
    output norm_t              norm_o,
    output num_t               num_o [9],
    output logic               zero_o
);

    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic               cmd_reg, zero1_reg;

    norm_t              norm_reg;
    num_t               num_reg [9];
    logic               zero2_reg;

    norm_t              norm_next;
    num_t               num_next [9];

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg    <= qx * qx;
            yy_reg    <= qy * qy;
            zz_reg    <= qz * qz;
            ww_reg    <= qw * qw;
            xy_reg    <= qx * qy;
            xz_reg    <= qx * qz;
            yz_reg    <= qy * qz;
            wx_reg    <= qw * qx;
            wy_reg    <= qw * qy;
            wz_reg    <= qw * qz;
            cmd_reg   <= cmd;
            zero1_reg <= (qx == '0) && (qy == '0) && (qz == '0) && (qw == '0);
        end
    end

    always_comb begin
        num_t xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
        xx = NW'(xx_reg);
        yy = NW'(yy_reg);
        zz = NW'(zz_reg);
        ww = NW'(ww_reg);
        xy = NW'(xy_reg);
        xz = NW'(xz_reg);
        yz = NW'(yz_reg);
        // transpose: flip the sign of the w cross terms
        wx = cmd_reg ? -NW'(wx_reg) : NW'(wx_reg);
        wy = cmd_reg ? -NW'(wy_reg) : NW'(wy_reg);
        wz = cmd_reg ? -NW'(wz_reg) : NW'(wz_reg);

        norm_next = SW'($unsigned(xx_reg)) + SW'($unsigned(yy_reg))
                  + SW'($unsigned(zz_reg)) + SW'($unsigned(ww_reg));

        num_next[0] = xx + ww - yy - zz;
        num_next[1] = (xy - wz) <<< 1;
        num_next[2] = (xz + wy) <<< 1;
        num_next[3] = (xy + wz) <<< 1;
        num_next[4] = yy + ww - xx - zz;
        num_next[5] = (yz - wx) <<< 1;
        num_next[6] = (xz - wy) <<< 1;
        num_next[7] = (yz + wx) <<< 1;
        num_next[8] = zz + ww - xx - yy;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm_reg  <= norm_next;
            num_reg   <= num_next;
            zero2_reg <= zero1_reg;
        end
    end

    assign norm_o = norm_reg;
    assign num_o  = num_reg;
    assign zero_o = zero2_reg;

endmodule

### src/q2r_div.sv
// One lane: signed numerator over norm, scaled and rounded, one quotient bit per stage.
// Depends on q2r_pkg.
module q2r_div import q2r_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  num_t        num_i,
    input  norm_t       norm_i,
    output logic [15:0] res_o
);

    logic [RW-1:0] r_reg   [0:QW-1];
    logic [DW-1:0] d_reg   [0:QW-1];
    logic          neg_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [15:0]   res_reg;

    num_t          mag;

    assign mag = num_i[NW-1] ? -num_i : num_i;

    // round half away: (|num| * 2^(FRAC+1) + n) / 2n
    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= num_i[NW-1];
            r_reg[0]   <= (RW'(mag[SW-1:0]) << QW) + RW'(norm_i);
            d_reg[0]   <= {norm_i, 1'b0};
            q_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int K = QW - 1 - i;
        logic [RW-1:0] dk;
        logic          ge;

        always_comb begin
            dk = RW'(d_reg[i]) << K;
            ge = r_reg[i] >= dk;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i+1]   <= q_reg[i] | (QW'(ge) << K);
                neg_reg[i+1] <= neg_reg[i];
            end
        end

        if (i < QW - 1) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[i+1] <= ge ? r_reg[i] - dk : r_reg[i];
                    d_reg[i+1] <= d_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= neg_reg[QW] ? -16'(q_reg[QW]) : 16'(q_reg[QW]);
        end
    end

    assign res_o = res_reg;

endmodule

### src/quaternion_to_rotation_matrix.sv
// Top level: quaternion in, normalized 3x3 rotation matrix out.
// Depends on q2r_pkg, q2r_front, q2r_div.
//
//  channel | ports                          | content
//  --------+--------------------------------+-----------------------------------
//  input   | s_valid s_ready s_cmd s_q*     | mode bit, quaternion x y z w
//  output  | m_valid m_ready m_m00..m_m22   | matrix Q1.14 row-major, zero flag
//          | m_zero_norm                    |
//
// LAT = FRAC + 6 register stages (20 at 14 fractional bits): two front stages,
// the divider input stage, one stage per quotient bit, sign and output.
// One item per cycle unless m_ready stalls; the divider bit stages set the depth.
// Reset clears only the valid bits. A stall on m_ready freezes every stage
// at once, so s_ready follows m_ready while the output holds a result.
module quaternion_to_rotation_matrix import q2r_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [15:0] s_qx,
    input  logic signed [15:0] s_qy,
    input  logic signed [15:0] s_qz,
    input  logic signed [15:0] s_qw,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_m00,
    output logic signed [15:0] m_m01,
    output logic signed [15:0] m_m02,
    output logic signed [15:0] m_m10,
    output logic signed [15:0] m_m11,
    output logic signed [15:0] m_m12,
    output logic signed [15:0] m_m20,
    output logic signed [15:0] m_m21,
    output logic signed [15:0] m_m22,
    output logic               m_zero_norm
);

    logic        en;
    logic        vld_reg [1:LAT];
    logic        zd_reg  [3:LAT-1];
    logic [15:0] mat_reg [9];
    logic        zero_reg;

    norm_t       norm;
    num_t        num [9];
    logic        zero;
    logic [15:0] res [9];

    assign en      = !vld_reg[LAT] || m_ready;
    assign s_ready = en;

    q2r_front u_front (
        .aclk   (aclk),
        .en     (en),
        .cmd    (s_cmd),
        .qx     (s_qx),
        .qy     (s_qy),
        .qz     (s_qz),
        .qw     (s_qw),
        .norm_o (norm),
        .num_o  (num),
        .zero_o (zero)
    );

    for (genvar e = 0; e < 9; e++) begin : g_lane
        q2r_div u_div (
            .aclk   (aclk),
            .en     (en),
            .num_i  (num[e]),
            .norm_i (norm),
            .res_o  (res[e])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= LAT; s++) vld_reg[s] <= 1'b0;
        end else if (en) begin
            vld_reg[1] <= s_valid;
            for (int s = 2; s <= LAT; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zd_reg[3] <= zero;
            for (int s = 4; s <= LAT - 1; s++) zd_reg[s] <= zd_reg[s-1];
            zero_reg <= zd_reg[LAT-1];
            for (int e = 0; e < 9; e++) begin
                if (zd_reg[LAT-1]) begin
                    mat_reg[e] <= (e == 0 || e == 4 || e == 8) ? ONE16 : '0;
                end else begin
                    mat_reg[e] <= res[e];
                end
            end
        end
    end

    assign m_valid     = vld_reg[LAT];
    assign m_zero_norm = zero_reg;
    assign m_m00       = mat_reg[0];
    assign m_m01       = mat_reg[1];
    assign m_m02       = mat_reg[2];
    assign m_m10       = mat_reg[3];
    assign m_m11       = mat_reg[4];
    assign m_m12       = mat_reg[5];
    assign m_m20       = mat_reg[6];
    assign m_m21       = mat_reg[7];
    assign m_m22       = mat_reg[8];

endmodule

### src/q2r_checker.sv
// Port-level checks for quaternion_to_rotation_matrix, bound to the top level.
// Depends on q2r_pkg.
module q2r_checker import q2r_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_m00,
    input logic signed [15:0] m_m01,
    input logic signed [15:0] m_m11,
    input logic signed [15:0] m_m22,
    input logic               m_zero_norm
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_m00) && $stable(m_zero_norm))
        else $error("stalled result changed");

    // input side opens exactly when the output is free or drains
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    a_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_norm |-> m_m00 == ONE16 && m_m11 == ONE16
                                    && m_m22 == ONE16 && m_m01 == 16'sd0)
        else $error("zero quaternion did not give identity");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_m00 <= ONE16 && m_m00 >= -ONE16 && m_m01 <= ONE16
                    && m_m01 >= -ONE16)
        else $error("matrix entry out of range");

endmodule

bind quaternion_to_rotation_matrix q2r_checker u_q2r_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_m00       (m_m00),
    .m_m01       (m_m01),
    .m_m11       (m_m11),
    .m_m22       (m_m22),
    .m_zero_norm (m_zero_norm)
);

### tb/tb_quaternion_to_rotation_matrix.sv
// Self-checking testbench for quaternion_to_rotation_matrix: random and corner-case
// quaternions go in over valid/ready, and each matrix that comes out is checked against an
// exact integer predictor. Depends on q2r_pkg and the DUT.
module tb_quaternion_to_rotation_matrix;
    timeunit 1ns;
    timeprecision 1ps;
    import q2r_pkg::*;

    typedef struct packed {
        logic               inv;
        logic signed [15:0] x, y, z, w;
    } quat_t;

    typedef struct packed {
        logic signed [8:0][15:0] m;
        logic                    zero;
    } matrix_t;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_cmd = 0, m_ready = 0;
    logic signed [15:0] s_qx = 0, s_qy = 0, s_qz = 0, s_qw = 0;
    logic s_ready, m_valid, m_zero_norm;
    logic signed [15:0] m_m00, m_m01, m_m02, m_m10, m_m11, m_m12, m_m20, m_m21, m_m22;

    quaternion_to_rotation_matrix DUT (.*);

    initial forever #5 aclk = ~aclk;

    quat_t   pending_quats[$];
    matrix_t expected_matrices[$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      calm = 0;
    int      hold_off = 0;
    int      src_gap = 0, snk_gap = 0;

    // Rounded num/n at FRAC fractional bits, ties away from zero, low 16 bits kept.
    function automatic logic [15:0] entry_of(longint num, longint n);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< (FRAC + 1)) + n) / (n <<< 1);
        if (num < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic matrix_t rotation_of(quat_t q);
        matrix_t r;
        longint x, y, z, w, n, s;
        longint num[9];
        x = q.x; y = q.y; z = q.z; w = q.w;
        n = x*x + y*y + z*z + w*w;
        r.zero = (n == 0);
        if (n == 0) begin
            for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? ONE16 : 16'sd0;
            return r;
        end
        s = q.inv ? -1 : 1;
        num[0] = x*x + w*w - y*y - z*z;
        num[1] = 2 * (x*y - s*w*z);
        num[2] = 2 * (x*z + s*w*y);
        num[3] = 2 * (x*y + s*w*z);
        num[4] = y*y + w*w - x*x - z*z;
        num[5] = 2 * (y*z - s*w*x);
        num[6] = 2 * (x*z - s*w*y);
        num[7] = 2 * (y*z + s*w*x);
        num[8] = z*z + w*w - x*x - y*y;
        for (int i = 0; i < 9; i++) r.m[i] = entry_of(num[i], n);
        return r;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 6)) - 16'sd3;
            3: return 16'($urandom_range(0, 600)) - 16'sd300;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_quat(logic inv, logic signed [15:0] x, y, z, w);
        quat_t q;
        q.inv = inv; q.x = x; q.y = y; q.z = z; q.w = w;
        pending_quats.push_back(q);
    endtask

    initial begin
        quat_t q;
        for (int c = 0; c < 2; c++) begin
            add_quat(1'(c), 0, 0, 0, 0);
            add_quat(1'(c), 0, 0, 0, 16'sh4000);
            add_quat(1'(c), 16'sh8000, 0, 0, 0);
            add_quat(1'(c), 0, 16'sh7fff, 0, 0);
            add_quat(1'(c), 0, 0, 16'sh8000, 0);
            add_quat(1'(c), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
            add_quat(1'(c), 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
            add_quat(1'(c), 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
            add_quat(1'(c), 1, 2, 3, 4);
            add_quat(1'(c), -1, 0, 0, 1);
            add_quat(1'(c), 0, 0, 0, -1);
        end
        for (int i = 0; i < 1550; i++) begin
            q.inv = $urandom_range(0, 1);
            q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp(); q.w = rand_comp();
            pending_quats.push_back(q);
        end
    end

    // Long receiver hold-off early on so the pipeline backs up into s_ready.
    initial begin
        repeat (40) @(posedge aclk);
        hold_off = 1;
        repeat (80) @(posedge aclk);
        hold_off = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else if (!s_valid || s_ready) begin
            // Current transfer done (or none): pick the next offer or a gap.
            if (s_valid && s_ready) void'(pending_quats.pop_front());
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 0;
            end else if (pending_quats.size() > (s_valid && s_ready ? 0 : 0)
                         && !(s_valid && s_ready && pending_quats.size() == 0)) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    src_gap <= $urandom_range(0, 4);
                    s_valid <= 0;
                end else if (pending_quats.size() > 0) begin
                    s_valid <= 1;
                    s_cmd <= pending_quats[0].inv;
                    s_qx <= pending_quats[0].x;
                    s_qy <= pending_quats[0].y;
                    s_qz <= pending_quats[0].z;
                    s_qw <= pending_quats[0].w;
                    expected_matrices.push_back(rotation_of(pending_quats[0]));
                end else begin
                    s_valid <= 0;
                end
            end else begin
                s_valid <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_ready <= 0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            snk_gap <= $urandom_range(0, 4);
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        matrix_t got, exp_m;
        if (aresetn && m_valid && m_ready) begin
            got.m = {m_m22, m_m21, m_m20, m_m12, m_m11, m_m10, m_m02, m_m01, m_m00};
            got.zero = m_zero_norm;
            if (expected_matrices.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
            end else begin
                exp_m = expected_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got.m[i] !== exp_m.m[i]) begin
                        $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                                 exp_m.m[i], got.m[i]);
                        errors++;
                    end
                if (got.zero !== exp_m.zero) begin
                    $display("%0t: zero_norm expected %b actual %b", $time, exp_m.zero,
                             got.zero);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        wait (pending_quats.size() < 200);
        calm = 1;
        wait (pending_quats.size() == 0 && !s_valid);
        wait (expected_matrices.size() == 0);
        repeat (LAT + 10) @(posedge aclk);
        if (errors == 0 && expected_matrices.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
